// ===== src/assert_macros.svh =====
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define SSAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen at a clock edge out of reset
`define SSAM_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/ssam_pkg.sv =====
package ssam_pkg;

  localparam int MAX_DEVICES     = 8;
  localparam int BLOCK_BYTES     = 512;
  localparam int MINIROOT_BLOCKS = 9216;

  localparam int BLK_W    = 33;
  localparam int STRIPE_W = 16;
  localparam int BYTES_W  = 24;
  localparam int SZ_W     = BYTES_W + 1 - $clog2(BLOCK_BYTES);
  localparam int NDEV_W   = $clog2(MAX_DEVICES + 1);
  localparam int DEV_W    = $clog2(MAX_DEVICES);
  localparam int DIV_W    = STRIPE_W + NDEV_W;

  typedef enum logic [2:0] {
    REG_STRIPE_BLOCKS = 3'd0,
    REG_DEVICE_COUNT  = 3'd1,
    REG_SWAP_TOTAL    = 3'd2,
    REG_MINIROOT_EN   = 3'd3,
    REG_PRESENT_MASK  = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PAST_END = 2'd1,
    ST_CROSSES  = 2'd2,
    ST_MISSING  = 2'd3
  } status_t;

  typedef struct packed {
    logic            past_end;
    logic            multi;
    logic [SZ_W-1:0] sz;
  } flags_t;

endpackage

// ===== src/striped_swap_address_mapper_core.sv =====
// one item accepted every cycle, results leave on out_valid in start order
// throughput: one item per clock, busy is never raised
// the pipeline holds a chain of 33 + 3 restoring divider cells, one bit each
// reset: synchronous active-low rst_n clears config to its defaults and
// drops every in-flight item; the receiver cannot stall results
module striped_swap_address_mapper_core import ssam_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_block_number,
  input  logic [23:0] in_byte_count,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [2:0]  out_device_index,
  output logic [31:0] out_device_block,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

`include "assert_macros.svh"

  localparam int TAG_A_W = $bits(flags_t);
  localparam int TAG_B_W = TAG_A_W + BLK_W;
  localparam int LAT     = 1 + BLK_W + DEV_W + 2;

  // configuration registers
  logic [STRIPE_W-1:0] stripe_r;
  logic [3:0]          ndev_r;
  logic [31:0]         total_r;
  logic                mini_r;
  logic [7:0]          mask_r;

  // config-derived values, zero stripe and zero count read as one, a count above 8 as 8
  logic [STRIPE_W-1:0] stripe_eff;
  logic [NDEV_W-1:0]   ndev_eff;
  logic [DIV_W-1:0]    span_r;

  always_comb begin
    stripe_eff = (stripe_r == '0) ? STRIPE_W'(1) : stripe_r;
    if (ndev_r == '0) begin
      ndev_eff = NDEV_W'(1);
    end else if (32'(ndev_r) > MAX_DEVICES) begin
      ndev_eff = NDEV_W'(MAX_DEVICES);
    end else begin
      ndev_eff = NDEV_W'(ndev_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stripe_r <= STRIPE_W'(1);
      ndev_r   <= 4'd1;
      total_r  <= '0;
      mini_r   <= 1'b0;
      mask_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STRIPE_BLOCKS: stripe_r <= cfg_data[STRIPE_W-1:0];
        REG_DEVICE_COUNT:  ndev_r   <= cfg_data[3:0];
        REG_SWAP_TOTAL:    total_r  <= cfg_data;
        REG_MINIROOT_EN:   mini_r   <= cfg_data[0];
        REG_PRESENT_MASK:  mask_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
    // a whole stripe row across all devices is the first divisor
    span_r <= DIV_W'(stripe_eff) * DIV_W'(ndev_eff);
  end

  assign busy = 1'b0;

  // entry stage: offset, block count and end-of-swap check
  logic [BLK_W-1:0]  blk_nxt;
  logic [SZ_W-1:0]   sz_nxt;
  logic [BLK_W:0]    end_blk;
  logic [BYTES_W:0]  bytes_up;
  logic              in_valid_r;
  logic [BLK_W-1:0]  blk_r;
  flags_t            flags_r;

  always_comb begin
    blk_nxt  = {1'b0, in_block_number} + (mini_r ? BLK_W'(MINIROOT_BLOCKS) : '0);
    bytes_up = {1'b0, in_byte_count} + (BYTES_W + 1)'(BLOCK_BYTES - 1);
    sz_nxt   = SZ_W'(bytes_up / BLOCK_BYTES);
    end_blk  = {1'b0, blk_nxt} + (BLK_W + 1)'(sz_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
    blk_r            <= blk_nxt;
    flags_r.sz       <= sz_nxt;
    flags_r.past_end <= end_blk > (BLK_W + 1)'(total_r);
    flags_r.multi    <= ndev_eff > NDEV_W'(1);
  end

  // chain a: block / (stripe * devices) gives row and offset in row
  logic               va  [BLK_W+1];
  logic [BLK_W-1:0]   na  [BLK_W+1];
  logic [DIV_W-1:0]   ra  [BLK_W+1];
  logic [TAG_A_W-1:0] ta  [BLK_W+1];

  assign va[0] = in_valid_r;
  assign na[0] = blk_r;
  assign ra[0] = '0;
  assign ta[0] = flags_r;

  for (genvar i = 0; i < BLK_W; i++) begin : g_row
    ssam_div_cell #(.NUM_W(BLK_W), .DEN_W(DIV_W), .TAG_W(TAG_A_W)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .valid_in  (va[i]),
      .num_in    (na[i]),
      .rem_in    (ra[i]),
      .den       (span_r),
      .tag_in    (ta[i]),
      .valid_out (va[i+1]),
      .num_out   (na[i+1]),
      .rem_out   (ra[i+1]),
      .tag_out   (ta[i+1])
    );
  end

  // chain b: offset in row / stripe gives device and offset in chunk;
  // the top bits of the offset seed the remainder as they stay below stripe
  logic               vb  [DEV_W+1];
  logic [DEV_W-1:0]   nb  [DEV_W+1];
  logic [STRIPE_W-1:0] rb [DEV_W+1];
  logic [TAG_B_W-1:0] tb  [DEV_W+1];

  assign vb[0] = va[BLK_W];
  assign nb[0] = ra[BLK_W][DEV_W-1:0];
  assign rb[0] = ra[BLK_W][DEV_W +: STRIPE_W];
  assign tb[0] = {ta[BLK_W], na[BLK_W]};

  for (genvar j = 0; j < DEV_W; j++) begin : g_dev
    ssam_div_cell #(.NUM_W(DEV_W), .DEN_W(STRIPE_W), .TAG_W(TAG_B_W)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .valid_in  (vb[j]),
      .num_in    (nb[j]),
      .rem_in    (rb[j]),
      .den       (stripe_eff),
      .tag_in    (tb[j]),
      .valid_out (vb[j+1]),
      .num_out   (nb[j+1]),
      .rem_out   (rb[j+1]),
      .tag_out   (tb[j+1])
    );
  end

  // multiply stage: row times stripe, chunk-crossing check
  flags_t             fb;
  logic [BLK_W-1:0]   row;
  logic               mv_r;
  logic               m_past_r;
  logic               m_cross_r;
  logic [DEV_W-1:0]   m_dev_r;
  logic [STRIPE_W-1:0] m_off_r;
  logic [31:0]        m_prod_r;
  logic [BLK_W+STRIPE_W-1:0] prod;
  logic [STRIPE_W:0]  chunk_end;

  always_comb begin
    fb        = flags_t'(tb[DEV_W][TAG_B_W-1:BLK_W]);
    row       = tb[DEV_W][BLK_W-1:0];
    prod      = row * stripe_eff;
    chunk_end = {1'b0, rb[DEV_W]} + (STRIPE_W + 1)'(fb.sz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else begin
      mv_r <= vb[DEV_W];
    end
    m_past_r  <= fb.past_end;
    m_cross_r <= fb.multi && (chunk_end > {1'b0, stripe_eff});
    m_dev_r   <= nb[DEV_W];
    m_off_r   <= rb[DEV_W];
    m_prod_r  <= prod[31:0];
  end

  // result stage, checks in priority order; a missing device keeps its address
  logic [31:0] dblk;
  assign dblk = m_prod_r + 32'(m_off_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= mv_r;
    end
    priority if (m_past_r) begin
      out_status       <= ST_PAST_END;
      out_device_index <= '0;
      out_device_block <= '0;
    end else if (m_cross_r) begin
      out_status       <= ST_CROSSES;
      out_device_index <= '0;
      out_device_block <= '0;
    end else begin
      out_status       <= mask_r[m_dev_r] ? ST_OK : ST_MISSING;
      out_device_index <= 3'(m_dev_r);
      out_device_block <= dblk;
    end
  end

  `SSAM_ASSERT(a_no_phantom, out_valid |-> $past(start, LAT), "result without item")
  `SSAM_ASSERT(a_no_loss, start |-> ##LAT out_valid, "item lost in pipeline")
  `SSAM_ASSERT(a_past_end_zero,
      out_valid && out_status == ST_PAST_END |-> {out_device_index, out_device_block} == '0,
      "past-end result not cleared")
  `SSAM_NEVER(a_never_busy, busy, "busy raised")

endmodule

// ===== src/ssam_div_cell.sv =====
module ssam_div_cell import ssam_pkg::*; #(
  parameter int NUM_W = 8,
  parameter int DEN_W = 8,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             valid_in,
  input  logic [NUM_W-1:0] num_in,
  input  logic [DEN_W-1:0] rem_in,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] tag_in,
  output logic             valid_out,
  output logic [NUM_W-1:0] num_out,
  output logic [DEN_W-1:0] rem_out,
  output logic [TAG_W-1:0] tag_out
);

  logic             valid_r;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [TAG_W-1:0] tag_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // one restoring step: quotient bit shifts in at the bottom
  always_comb begin
    trial   = {rem_in, num_in[NUM_W-1]};
    diff    = trial - {1'b0, den};
    ge      = trial >= {1'b0, den};
    rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    num_nxt = {num_in[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    tag_r <= tag_in;
  end

  assign valid_out = valid_r;
  assign num_out   = num_r;
  assign rem_out   = rem_r;
  assign tag_out   = tag_r;

endmodule

// ===== test/striped_swap_address_mapper_core_tb.sv =====
module striped_swap_address_mapper_core_tb import ssam_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // pipeline depth given by the block, plus some slack for draining
  localparam int PIPE_CYCLES = 39;
  localparam int DRAIN_CYCLES = PIPE_CYCLES + 20;
  localparam int RANDOM_ITEMS = 1250;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_block_number = '0;
  logic [23:0] in_byte_count = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [2:0]  out_device_index;
  logic [31:0] out_device_block;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  striped_swap_address_mapper_core DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_block_number(in_block_number), .in_byte_count(in_byte_count),
    .out_valid(out_valid), .out_status(out_status),
    .out_device_index(out_device_index), .out_device_block(out_device_block),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  typedef struct packed {
    status_t     status;
    logic [2:0]  dev;
    logic [31:0] dblk;
  } mapping_t;

  // predictor's copy of the register file
  logic [15:0] stripe_reg;
  logic [3:0]  ndev_reg;
  logic [31:0] swap_total_reg;
  logic        miniroot_reg;
  logic [7:0]  present_reg;

  mapping_t pending_maps[$];
  int       mismatch_count = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch on %s: got %0h, want %0h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // stripe translation, all sums done at 64 bits so nothing wraps
  function automatic mapping_t map_request(input logic [31:0] blk_in,
                                           input logic [23:0] bytes);
    logic [63:0] blk, nblk, stripe, ndev, off, seg, devn, dblk;
    mapping_t    m;
    blk = blk_in;
    nblk = (64'(bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
    stripe = (stripe_reg == 0) ? 64'd1 : 64'(stripe_reg);
    ndev = (ndev_reg == 0) ? 64'd1 : 64'(ndev_reg);
    devn = 0;
    m = '0;
    if (ndev > MAX_DEVICES) ndev = MAX_DEVICES;
    if (miniroot_reg) blk = blk + MINIROOT_BLOCKS;
    if (blk + nblk > 64'(swap_total_reg)) begin
      m.status = ST_PAST_END;
      return m;
    end
    dblk = blk;
    if (ndev > 1) begin
      off = blk % stripe;
      if (off + nblk > stripe) begin
        m.status = ST_CROSSES;
        return m;
      end
      seg = blk / stripe;
      devn = seg % ndev;
      dblk = (seg / ndev) * stripe + off;
    end
    m.status = (devn >= 8 || !present_reg[devn[2:0]]) ? ST_MISSING : ST_OK;
    m.dev = devn[2:0];
    m.dblk = dblk[31:0];
    return m;
  endfunction

  // results are sampled at the edge that ends their strobe cycle
  always @(posedge clk) begin
    mapping_t want;
    if (rst_n && out_valid) begin
      if (pending_maps.size() == 0) begin
        $display("unexpected result at %0t", $time);
        mismatch_count++;
      end else begin
        want = pending_maps.pop_front();
        if (out_status !== want.status) report("status", 32'(out_status), 32'(want.status));
        if (out_device_index !== want.dev)
          report("device_index", 32'(out_device_index), 32'(want.dev));
        if (out_device_block !== want.dblk) report("device_block", out_device_block, want.dblk);
      end
    end
  end

  // one cycle with the write enable high, then the enable is driven low again before the task returns
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_STRIPE_BLOCKS: stripe_reg = value[15:0];
      REG_DEVICE_COUNT:  ndev_reg = value[3:0];
      REG_SWAP_TOTAL:    swap_total_reg = value;
      REG_MINIROOT_EN:   miniroot_reg = value[0];
      REG_PRESENT_MASK:  present_reg = value[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // drive one item; start stays high across back-to-back items
  task automatic send_item(input logic [31:0] blk, input logic [23:0] bytes, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_block_number <= blk;
    in_byte_count <= bytes;
    pending_maps.push_back(map_request(blk, bytes));
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_config(input bit extremes);
    write_reg(REG_STRIPE_BLOCKS, extremes ? ($urandom_range(1) ? 16'hFFFF : 16'd0)
                                          : $urandom_range(1, 40));
    write_reg(REG_DEVICE_COUNT, $urandom_range(0, 15));
    write_reg(REG_SWAP_TOTAL, extremes ? 32'hFFFF_FFFF : $urandom_range(0, 20000));
    write_reg(REG_MINIROOT_EN, $urandom_range(0, 1));
    write_reg(REG_PRESENT_MASK, $urandom_range(0, 255));
  endtask

  // directed rows: expected value typed in when obvious, else predicted
  typedef struct {
    logic [31:0] blk;
    logic [23:0] bytes;
    bit          typed;
    mapping_t    want;
  } row_t;

  row_t rows[] = '{
    // after reset: total 0, anything of nonzero length past end
    '{32'd0, 24'd1, 1'b1, '{ST_PAST_END, 3'd0, 32'd0}},
    '{32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1, '{ST_PAST_END, 3'd0, 32'd0}},
    // zero length at block 0 fits, mask 0 so device missing
    '{32'd0, 24'd0, 1'b1, '{ST_MISSING, 3'd0, 32'd0}}
  };

  row_t cfg_rows[] = '{
    '{32'd0, 24'd0, 1'b0, '0},
    '{32'd100, 24'd512, 1'b0, '0},
    '{32'd101, 24'd513, 1'b0, '0},
    '{32'd7, 24'd1, 1'b0, '0},
    '{32'd15, 24'd512, 1'b0, '0},
    '{32'd15, 24'd1024, 1'b0, '0},
    '{32'd31, 24'd0, 1'b0, '0},
    '{32'hFFFF_FFFF, 24'd0, 1'b0, '0},
    '{32'hAAAA_AAAA, 24'h55_5555, 1'b0, '0},
    '{32'h5555_5555, 24'hAA_AAAA, 1'b0, '0},
    '{32'd1000, 24'hFF_FFFF, 1'b0, '0},
    '{32'd63, 24'd511, 1'b0, '0}
  };

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    mapping_t m;
    int       n;
    stripe_reg = 16'd1; ndev_reg = 4'd1; swap_total_reg = '0;
    miniroot_reg = 1'b0; present_reg = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults
    foreach (rows[i]) begin
      m = map_request(rows[i].blk, rows[i].bytes);
      if (m !== rows[i].want) begin
        $display("table row %0d disagrees with prediction", i);
        mismatch_count++;
      end
      send_item(rows[i].blk, rows[i].bytes, 0);
    end
    drain();

    // striped set-up: 8 devices, chunk 16, most present, miniroot off
    write_reg(REG_STRIPE_BLOCKS, 16'd16);
    write_reg(REG_DEVICE_COUNT, 4'd8);
    write_reg(REG_SWAP_TOTAL, 32'hFFFF_FFFF);
    write_reg(REG_MINIROOT_EN, 1'b0);
    write_reg(REG_PRESENT_MASK, 8'h7F);
    foreach (cfg_rows[i]) send_item(cfg_rows[i].blk, cfg_rows[i].bytes, 0);
    drain();
    write_reg(REG_PRESENT_MASK, 8'hFF);
    // miniroot offset plus saturating device count and a zero stripe read as one
    write_reg(REG_MINIROOT_EN, 1'b1);
    write_reg(REG_DEVICE_COUNT, 4'd15);
    write_reg(REG_STRIPE_BLOCKS, 16'd0);
    foreach (cfg_rows[i]) send_item(cfg_rows[i].blk, cfg_rows[i].bytes, 0);
    drain();

    // random phases, each with its own register setting
    n = 0;
    for (int phase = 0; n < RANDOM_ITEMS; phase++) begin
      random_config(phase % 4 == 3);
      for (int k = 0; k < 80 && n < RANDOM_ITEMS; k++, n++) begin
        logic [31:0] blk;
        logic [23:0] bytes;
        int          gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 0;
        case ($urandom_range(0, 4))
          0: begin
            blk = $urandom; bytes = $urandom;
          end
          1: begin
            blk = $urandom_range(0, 20000); bytes = $urandom_range(0, 24000);
          end
          default: begin
            // mostly in range with transfers of up to 8 blocks
            blk = $urandom_range(0, swap_total_reg > 40 ? 16'hFFFF : 200);
            if (swap_total_reg != 32'hFFFF_FFFF) blk = blk % (swap_total_reg + 1);
            bytes = $urandom_range(0, 512 * 8);
          end
        endcase
        send_item(blk, bytes, gap);
      end
      // hold off until the pipe is empty before reconfiguring
      drain();
    end

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
